/* hw/rtl/tted_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tted_pkg: shared types, constants and arithmetic helpers
// Sample, gain and address types, the tap weights, the register indexes and
// the round-and-saturate helpers used by the three-tap echo delay.
// ----------------------------------------------------------------------------
package tted_pkg;

  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned GAIN_FRAC    = 16;
  localparam int unsigned ADDR_BITS    = 18;
  localparam int unsigned HISTORY_DEPTH = 1 << ADDR_BITS;
  localparam int unsigned REG_BITS     = 17;
  localparam int unsigned REG_IDX_BITS = 2;
  localparam int unsigned COEF_BITS    = GAIN_FRAC + 2;
  localparam int unsigned WIDE_BITS    = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned MEM_BITS     = 2 * SAMPLE_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [WIDE_BITS-1:0]   wide_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [REG_BITS-1:0]           reg_t;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_TAP_DELAY = 2'd0,
    REG_FEEDBACK  = 2'd1,
    REG_WET_MIX   = 2'd2
  } reg_idx_e;

  // Unity gain and the 0.5 / 0.3 / 0.2 tap weights, rounded to the nearest LSB.
  localparam coef_t GAIN_ONE = coef_t'(1 << GAIN_FRAC);
  localparam coef_t TAP_W1   = coef_t'(1 << (GAIN_FRAC - 1));
  localparam coef_t TAP_W2   = coef_t'((3 * (1 << GAIN_FRAC) + 5) / 10);
  localparam coef_t TAP_W3   = coef_t'((2 * (1 << GAIN_FRAC) + 5) / 10);

  localparam wide_t   ROUND_HALF = wide_t'(1 << (GAIN_FRAC - 1));
  localparam wide_t   WIDE_MAX   = wide_t'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam wide_t   WIDE_MIN   = ~WIDE_MAX;
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam sample_t SAMPLE_MIN = ~SAMPLE_MAX;

  // Signed sample times signed gain, full precision.
  function automatic wide_t mul(sample_t a, coef_t b);
    return wide_t'(a) * wide_t'(b);
  endfunction

  // Round half toward plus infinity, then drop the fraction bits.
  function automatic wide_t round_shift(wide_t v);
    return (v + ROUND_HALF) >>> GAIN_FRAC;
  endfunction

  function automatic sample_t saturate(wide_t v);
    sample_t r;
    if (v > WIDE_MAX) begin
      r = SAMPLE_MAX;
    end else if (v < WIDE_MIN) begin
      r = SAMPLE_MIN;
    end else begin
      r = sample_t'(v);
    end
    return r;
  endfunction

  function automatic sample_t sat_round(wide_t v);
    return saturate(round_shift(v));
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/three_tap_echo_delay_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// three_tap_echo_delay_unit: stereo three-tap feedback echo
// A frame steps through RD1, RD2, RD3, ACC3, ECHO, MULT, WRITE and OUT, and the
// next is taken only after OUT, set by the single-port history memory (three
// tap reads and one write per frame) and the multiply chain.
// Reset: delay and gains go to zero, the write pointer to entry zero, and the
// history reads as silence until written; no clearing pass is needed.
// ----------------------------------------------------------------------------
module three_tap_echo_delay_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tted_pkg::REG_IDX_BITS-1:0]     cfg_index_i,
  input  tted_pkg::reg_t                        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  tted_pkg::sample_t                     left_in_i,
  input  tted_pkg::sample_t                     right_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output tted_pkg::sample_t                     left_out_o,
  output tted_pkg::sample_t                     right_out_o
);
  import tted_pkg::*;

  // Frame sequencer. Reads go out in RD1..RD3, the read data comes back in the
  // next state and is folded into the echo accumulators in RD2, RD3 and ACC3.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD1   = 4'd1;
  localparam logic [3:0] ST_RD2   = 4'd2;
  localparam logic [3:0] ST_RD3   = 4'd3;
  localparam logic [3:0] ST_ACC3  = 4'd4;
  localparam logic [3:0] ST_ECHO  = 4'd5;
  localparam logic [3:0] ST_MULT  = 4'd6;
  localparam logic [3:0] ST_WRITE = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0] state_q, state_d;

  // Configuration registers, stored raw; the gains are clamped where used.
  reg_t cfg_delay_q;
  reg_t cfg_fb_q;
  reg_t cfg_mix_q;

  // Write pointer and fill tracking. Entries are written strictly in pointer
  // order, so an entry holds data once the pointer has passed it or wrapped.
  addr_t widx_q;
  logic  wrapped_q;

  // History memory: left sample in the upper half, right in the lower half.
  logic [MEM_BITS-1:0] hist_mem [HISTORY_DEPTH];
  logic [MEM_BITS-1:0] rd_q;
  logic                rd_ok_q;
  logic                mem_we;
  addr_t               mem_addr;
  logic [MEM_BITS-1:0] mem_wdata;
  logic                addr_filled;

  addr_t off1, off2, off3, off_sel;

  sample_t in_l_q, in_r_q;
  sample_t tap_l, tap_r;
  wide_t   acc_l_q, acc_r_q;
  sample_t echo_l_q, echo_r_q;
  wide_t   fbp_l_q, fbp_r_q;
  wide_t   mix_l_q, mix_r_q;
  sample_t hist_l, hist_r;

  coef_t fb_gain, wet_gain, dry_gain;

  logic    out_valid_q;
  sample_t left_out_q, right_out_q;
  logic    in_take;
  logic    out_load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_take     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

  // Gains above unity are treated as unity.
  assign fb_gain  = (cfg_fb_q > reg_t'(GAIN_ONE)) ? GAIN_ONE : coef_t'({1'b0, cfg_fb_q});
  assign wet_gain = (cfg_mix_q > reg_t'(GAIN_ONE)) ? GAIN_ONE : coef_t'({1'b0, cfg_mix_q});
  assign dry_gain = GAIN_ONE - wet_gain;

  // Tap offsets wrap modulo the power-of-two depth, so plain truncation works.
  assign off1 = addr_t'(cfg_delay_q);
  assign off2 = addr_t'({cfg_delay_q, 1'b0});
  assign off3 = off1 + off2;

  always_comb begin
    case (state_q)
      ST_RD1:  off_sel = off1;
      ST_RD2:  off_sel = off2;
      ST_RD3:  off_sel = off3;
      default: off_sel = '0;
    endcase
  end

  // A zero offset reads the entry at the pointer before this frame's write.
  assign mem_addr    = widx_q - off_sel;
  assign addr_filled = wrapped_q || (mem_addr < widx_q);
  assign mem_we      = (state_q == ST_WRITE);

  // Unwritten entries read as silence.
  assign tap_l = rd_ok_q ? sample_t'(rd_q[MEM_BITS-1:SAMPLE_BITS]) : '0;
  assign tap_r = rd_ok_q ? sample_t'(rd_q[SAMPLE_BITS-1:0]) : '0;

  // New history entry: input plus the fed-back echo, saturated.
  assign hist_l    = saturate(wide_t'(in_l_q) + round_shift(fbp_l_q));
  assign hist_r    = saturate(wide_t'(in_r_q) + round_shift(fbp_r_q));
  assign mem_wdata = {hist_l, hist_r};

  // Single-port history memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_addr] <= mem_wdata;
    end else begin
      rd_q    <= hist_mem[mem_addr];
      rd_ok_q <= addr_filled;
    end
  end

  always_comb begin
    case (state_q)
      ST_IDLE:  state_d = in_take ? ST_RD1 : ST_IDLE;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = ST_RD3;
      ST_RD3:   state_d = ST_ACC3;
      ST_ACC3:  state_d = ST_ECHO;
      ST_ECHO:  state_d = ST_MULT;
      ST_MULT:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_OUT;
      ST_OUT:   state_d = out_load ? ST_IDLE : ST_OUT;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath. At most two multiplies per channel in a step (both in MULT),
  // registered before the next step.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          in_l_q <= left_in_i;
          in_r_q <= right_in_i;
        end
      end
      ST_RD2: begin
        acc_l_q <= mul(tap_l, TAP_W1);
        acc_r_q <= mul(tap_r, TAP_W1);
      end
      ST_RD3: begin
        acc_l_q <= acc_l_q + mul(tap_l, TAP_W2);
        acc_r_q <= acc_r_q + mul(tap_r, TAP_W2);
      end
      ST_ACC3: begin
        acc_l_q <= acc_l_q + mul(tap_l, TAP_W3);
        acc_r_q <= acc_r_q + mul(tap_r, TAP_W3);
      end
      ST_ECHO: begin
        echo_l_q <= sat_round(acc_l_q);
        echo_r_q <= sat_round(acc_r_q);
      end
      ST_MULT: begin
        fbp_l_q <= mul(echo_l_q, fb_gain);
        fbp_r_q <= mul(echo_r_q, fb_gain);
        mix_l_q <= mul(in_l_q, dry_gain);
        mix_r_q <= mul(in_r_q, dry_gain);
      end
      ST_WRITE: begin
        mix_l_q <= mix_l_q + mul(echo_l_q, wet_gain);
        mix_r_q <= mix_r_q + mul(echo_r_q, wet_gain);
      end
      ST_OUT: begin
        if (out_load) begin
          left_out_q  <= sat_round(mix_l_q);
          right_out_q <= sat_round(mix_r_q);
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      widx_q      <= '0;
      wrapped_q   <= 1'b0;
      cfg_delay_q <= '0;
      cfg_fb_q    <= '0;
      cfg_mix_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TAP_DELAY: cfg_delay_q <= cfg_data_i;
          REG_FEEDBACK:  cfg_fb_q    <= cfg_data_i;
          REG_WET_MIX:   cfg_mix_q   <= cfg_data_i;
          default: ;
        endcase
      end

      // The pointer moves on once the frame's result is in the output register.
      if (out_load) begin
        widx_q <= widx_q + addr_t'(1);
        if (widx_q == '1) begin
          wrapped_q <= 1'b1;
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* tb/sv/three_tap_echo_delay_unit_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// three_tap_echo_delay_unit_tb: self-checking bench for the stereo echo delay
// Drives stereo frames through the valid/ready input channel and predicts every
// output frame with a behavioral copy of the echo: its own tap delay, feedback
// and mix registers, its own history of both channels and its own write
// pointer. Output beats are checked in order against the predicted frames.
// Directed cases come first, then random frames under several idle and stall
// profiles, then a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module three_tap_echo_delay_unit_tb;
  import tted_pkg::*;

  // Register index that maps to nothing; writes to it must leave all settings
  // alone.
  localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED = REG_IDX_BITS'(3);

  // Q1.16 arithmetic of the echo, kept in 64-bit signed integers.
  localparam longint Q16_UNITY  = 64'sd65536;
  localparam longint Q16_HALF   = 64'sd32768;
  localparam longint W_NEAR     = 64'sd32768;  // 0.5 on the 1x tap
  localparam longint W_MID      = 64'sd19661;  // 0.3 on the 2x tap
  localparam longint W_FAR      = 64'sd13107;  // 0.2 on the 3x tap
  localparam longint PEAK_POS   = 64'sd8388607;
  localparam longint PEAK_NEG   = -64'sd8388608;
  localparam longint DEPTH_L    = longint'(HISTORY_DEPTH);

  // Cycles with no accepted beat on either channel before the run is abandoned.
  // The longest deliberate stall is the receiver hold-off, HOLD_CYCLES long.
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    sample_t left;
    sample_t right;
  } stereo_frame_t;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    cfg_we_i    = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_index_i = '0;
  reg_t    cfg_data_i  = '0;
  logic    in_valid_i  = 1'b0;
  logic    in_ready_o;
  sample_t left_in_i   = '0;
  sample_t right_in_i  = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  sample_t left_out_o;
  sample_t right_out_o;

  three_tap_echo_delay_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

  // Shadow of the configuration registers, as last written.
  longint tap_delay_q     = 0;
  longint feedback_gain_q = 0;
  longint wet_mix_q       = 0;

  // Shadow of the delay history. Both channels share one sparse store, keyed
  // by channel times depth plus address; an entry never written is silence.
  longint echo_history [int];
  longint write_pos = 0;

  stereo_frame_t expected_frames [$];
  int unsigned   mismatch_count = 0;

  // Idle profile, changed per phase by the test tasks.
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  // Set by a test to ask the receiver for one long hold-off.
  int unsigned hold_request       = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Behavioral echo
  // --------------------------------------------------------------------------

  function automatic longint clip_sample(longint v);
    if (v > PEAK_POS) begin
      return PEAK_POS;
    end
    if (v < PEAK_NEG) begin
      return PEAK_NEG;
    end
    return v;
  endfunction

  // Rounds half toward plus infinity: add one half LSB, then floor the shift.
  function automatic longint round_q16(longint v);
    return (v + Q16_HALF) >>> GAIN_FRAC;
  endfunction

  function automatic int history_key(int channel, addr_t addr);
    return channel * int'(HISTORY_DEPTH) + int'(addr);
  endfunction

  function automatic longint history_at(int channel, addr_t addr);
    int key;
    key = history_key(channel, addr);
    return echo_history.exists(key) ? echo_history[key] : 0;
  endfunction

  // Address of the tap that lies multiple times the tap delay behind the write
  // pointer. The offset wraps modulo the depth, so a long delay on the 3x tap
  // can land just behind the pointer again.
  function automatic addr_t tap_address(longint multiple);
    longint offset;
    offset = (tap_delay_q * multiple) % DEPTH_L;
    return addr_t'((write_pos + DEPTH_L - offset) % DEPTH_L);
  endfunction

  // One channel of one frame: read the three taps, write the fed-back sample at
  // the pointer, and return the dry/wet blend. Gains above unity are clamped.
  function automatic longint echo_channel(int channel, longint dry,
                                          addr_t near_a, addr_t mid_a, addr_t far_a);
    longint fb;
    longint mix;
    longint echo;
    fb   = (feedback_gain_q > Q16_UNITY) ? Q16_UNITY : feedback_gain_q;
    mix  = (wet_mix_q > Q16_UNITY) ? Q16_UNITY : wet_mix_q;
    echo = clip_sample(round_q16(W_NEAR * history_at(channel, near_a)
                               + W_MID * history_at(channel, mid_a)
                               + W_FAR * history_at(channel, far_a)));
    echo_history[history_key(channel, addr_t'(write_pos))] =
        clip_sample(dry + round_q16(echo * fb));
    return clip_sample(round_q16(dry * (Q16_UNITY - mix) + echo * mix));
  endfunction

  // Advances the shadow by one accepted frame and queues the frame it yields.
  task automatic predict_echo_frame(input sample_t left, input sample_t right);
    addr_t         near_a;
    addr_t         mid_a;
    addr_t         far_a;
    stereo_frame_t frame;
    near_a      = tap_address(1);
    mid_a       = tap_address(2);
    far_a       = tap_address(3);
    frame.left  = sample_t'(echo_channel(0, longint'(left), near_a, mid_a, far_a));
    frame.right = sample_t'(echo_channel(1, longint'(right), near_a, mid_a, far_a));
    write_pos   = (write_pos + 1) % DEPTH_L;
    expected_frames.push_back(frame);
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one frame and returns at the clock edge where it is taken. It is
  // always entered at a rising edge. A random gap may come first; valid is
  // only lowered for a gap, never between back-to-back beats.
  task automatic send_frame(input sample_t left, input sample_t right);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_in_i  <= left;
    right_in_i <= right;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    predict_echo_frame(left, right);
  endtask

  // Drops valid after the last beat and moves on by one edge, so that the next
  // caller never assigns valid twice in one time step.
  task automatic stop_sending();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_for_outputs();
    while (expected_frames.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One register write. The shadow follows at the edge that performs it.
  task automatic write_reg(input logic [REG_IDX_BITS-1:0] index, input reg_t value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (index)
      REG_TAP_DELAY: tap_delay_q     = longint'(value);
      REG_FEEDBACK:  feedback_gain_q = longint'(value);
      REG_WET_MIX:   wet_mix_q       = longint'(value);
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Settings change only once the block has handed back every frame it took.
  task automatic set_echo_params(input reg_t delay, input reg_t feedback, input reg_t wet);
    stop_sending();
    wait_for_outputs();
    write_reg(REG_TAP_DELAY, delay);
    write_reg(REG_FEEDBACK, feedback);
    write_reg(REG_WET_MIX, wet);
  endtask

  // --------------------------------------------------------------------------
  // Random values
  // --------------------------------------------------------------------------

  function automatic sample_t pick_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    end
    if (sel < 35) begin
      return sample_t'(int'($urandom_range(2000)) - 1000);
    end
    return sample_t'($urandom);
  endfunction

  // Mostly short delays so the taps reach frames already written. Delays just
  // above a third of the depth put the wrapped 3x tap a few frames back.
  function automatic reg_t pick_delay();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) begin
      return reg_t'($urandom_range(48, 1));
    end
    if (sel < 72) begin
      return reg_t'($urandom_range(3));
    end
    if (sel < 85) begin
      return reg_t'($urandom_range(87400, 87382));
    end
    if (sel < 92) begin
      return reg_t'($urandom_range(87381));
    end
    return reg_t'($urandom_range(131071, 87382));
  endfunction

  function automatic reg_t pick_gain();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 20) begin
      return reg_t'(Q16_UNITY);
    end
    if (sel < 30) begin
      return reg_t'($urandom_range(131071, 65537));
    end
    if (sel < 40) begin
      return '0;
    end
    return reg_t'($urandom_range(65535));
  endfunction

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // The receiver stalls at random, or for one long stretch when a test asks.
  // At most one assignment to ready happens per edge.
  always begin
    int unsigned span;
    @(posedge clk_i);
    if (hold_request != 0) begin
      span         = hold_request;
      hold_request = 0;
      out_ready_i <= 1'b0;
      repeat (span) @(posedge clk_i);
    end
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Every output beat is compared with the oldest predicted frame. Values are
  // read right at the edge, before any of this edge's updates land.
  always @(posedge clk_i) begin
    stereo_frame_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected output beat: left_out %0d right_out %0d",
               left_out_o, right_out_o);
        mismatch_count++;
      end else begin
        want = expected_frames.pop_front();
        if (left_out_o !== want.left) begin
          $error("left_out: expected %0d, got %0d", want.left, left_out_o);
          mismatch_count++;
        end
        if (right_out_o !== want.right) begin
          $error("right_out: expected %0d, got %0d", want.right, right_out_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: the run is abandoned when no beat moves on either channel for
  // too long, which also catches frames that never come back.
  always @(posedge clk_i) begin
    int unsigned quiet_cycles;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // With all-zero settings the output is the dry input. Covers the extremes
  // and alternating bit patterns of both samples.
  task automatic test_passthrough();
    set_echo_params('0, '0, '0);
    send_frame('0, '0);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(sample_t'(-1), sample_t'(1));
    send_frame(sample_t'(24'h555555), sample_t'(24'hAAAAAA));
    send_frame(sample_t'(24'hAAAAAA), sample_t'(24'h555555));
  endtask

  // Unity feedback on a short delay with full-scale input drives the history
  // writes into saturation on the positive rail.
  task automatic test_echo_saturation();
    set_echo_params(reg_t'(2), reg_t'(Q16_UNITY), reg_t'(32768));
    repeat (4) send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MIN);
    send_frame('0, '0);
  endtask

  // Zero delay reads the pointer entry before it is overwritten; gains above
  // unity are clamped.
  task automatic test_zero_delay_clamp();
    set_echo_params('0, reg_t'(131071), reg_t'(131071));
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(sample_t'(123456), sample_t'(-654321));
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
  endtask

  // Tap offsets past the depth wrap around. With this delay the 3x tap lands
  // two frames behind the pointer; at the largest delay the 3x tap wraps and
  // the 2x tap sits just two entries ahead of the pointer.
  task automatic test_tap_wrap();
    set_echo_params(reg_t'(87382), reg_t'(40000), reg_t'(Q16_UNITY));
    send_frame(sample_t'(4000000), sample_t'(-4000000));
    send_frame(sample_t'(-2500000), sample_t'(2500000));
    send_frame(sample_t'(1000), sample_t'(-1000));
    send_frame('0, '0);
    set_echo_params(reg_t'(131071), reg_t'(Q16_UNITY), reg_t'(50000));
    send_frame(SAMPLE_MAX, sample_t'(77));
    send_frame(sample_t'(-77), SAMPLE_MIN);
  endtask

  // A write to the unmapped index must change nothing.
  task automatic test_unmapped_register();
    set_echo_params(reg_t'(87381), reg_t'(20000), reg_t'(10000));
    write_reg(REG_UNMAPPED, reg_t'(5));
    send_frame(sample_t'(3000000), sample_t'(-3000000));
    send_frame(sample_t'(-1), '0);
  endtask

  // Random frames under one idle profile, with fresh settings every block.
  task automatic run_random_phase(input int unsigned send_idle, input int unsigned recv_stall,
                                  input int unsigned frames);
    int unsigned sent;
    sender_idle_pct    = send_idle;
    receiver_stall_pct = recv_stall;
    sent = 0;
    while (sent < frames) begin
      set_echo_params(pick_delay(), pick_gain(), pick_gain());
      repeat (65) begin
        send_frame(pick_sample(), pick_sample());
        sent++;
      end
    end
  endtask

  // The receiver holds off for a long stretch while frames keep coming, so
  // the block fills up and has to stall its input.
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    set_echo_params(reg_t'(4), reg_t'(50000), reg_t'(30000));
    hold_request = HOLD_CYCLES;
    repeat (160) send_frame(pick_sample(), pick_sample());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough();
    test_echo_saturation();
    test_zero_delay_clamp();
    test_tap_wrap();
    test_unmapped_register();

    run_random_phase(0, 0, 260);
    run_random_phase(70, 0, 260);
    run_random_phase(0, 70, 260);
    run_random_phase(17, 17, 260);
    test_backpressure();

    // Let the last frames drain, then give the block a little longer than its
    // latency to show any stray beat.
    stop_sending();
    wait_for_outputs();
    repeat (16) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
